### rtl/core/cpd_pkg.sv
// Shared types and constants for the closest pair distance block.
// Used by the chain cells, the square root unit and the top level.
package cpd_pkg;

	localparam int COORD_W = 24;
	localparam int SQ_W = 50;
	localparam int DIST_W = 25;
	localparam int SQRT_STEPS = SQ_W / 2;
	localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);
	localparam int SQRT_REM_W = DIST_W + 3;
	localparam int CPD_MAX_POINTS = 64;

	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_FAR_LIMIT = 1'd0;
	localparam logic [DIST_W-1:0] FAR_LIMIT_RESET = 25'd2560000;
	localparam logic [SQ_W-1:0] SQ_ALL_ONES = {SQ_W{1'b1}};

	typedef enum logic {
		SQ_IDLE,
		SQ_RUN
	} sq_state_t;

	typedef struct packed {
		logic valid;
		logic keep;
		logic last;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} pt_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic [SQ_W-1:0] best;
	} min_t;

endpackage

### rtl/core/closest_pair_distance.sv
// Top level of the closest pair distance block: stream ports, register port,
// the chain of cpd_cell instances and the cpd_sqrt unit. Depends on cpd_pkg.
//
// Points stream in one per cycle while s_tready is high, each traveling down
// a chain of MAX_POINTS cells; cell k keeps the k-th point of the set and
// compares it with every later point passing by. After the point marked
// tlast the input stalls until the result is taken: the last point travels
// to the end of the chain, the set minimum then passes through the square
// root unit and into the result register. Points beyond MAX_POINTS are
// ignored and flagged.
module closest_pair_distance
	import cpd_pkg::*;
#(
	parameter int MAX_POINTS = CPD_MAX_POINTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [47:0]       s_tdata,  // coord_x [23:0], coord_y [47:24]
	input  logic              s_tlast,  // set_end
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,  // min_distance [24:0], zero [31:25]
	output logic [1:0]        m_tuser,  // no_pair [0], points_dropped [1]
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
	localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

	logic [DIST_W-1:0] far_limit_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic cfg_wr;

	logic [CNT_W-1:0] count_q, count_nxt;
	logic ovf_q, ovf_nxt, keep;
	logic busy_q, few_q, drop_q;
	logic in_xfer, out_xfer;

	pt_t entry_q;
	logic [CNT_W-1:0] entry_idx_q;
	pt_t pt_chain [MAX_POINTS+1];
	logic [CNT_W-1:0] idx_chain [MAX_POINTS+1];
	min_t min_chain [MAX_POINTS];

	min_t tail;
	logic [SQ_W-1:0] gbest_q, merged;
	logic sq_start, sq_done;
	logic [DIST_W-1:0] sq_root;

	logic m_valid_q, nopair_q, dropped_q;
	logic [DIST_W-1:0] dist_q;

	// Register port
	assign pready = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (reg_idx)
			REG_FAR_LIMIT: prdata = {{(DATA_W-DIST_W){1'b0}}, far_limit_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			far_limit_q <= FAR_LIMIT_RESET;
		end else if (cfg_wr && (reg_idx == REG_FAR_LIMIT)) begin
			far_limit_q <= pwdata[DIST_W-1:0];
		end
	end

	// Input side
	assign s_tready = !busy_q;
	assign in_xfer = s_tvalid && s_tready;
	assign out_xfer = m_valid_q && m_tready;
	assign keep = (count_q != CNT_MAX);
	assign count_nxt = keep ? count_q + 1'b1 : count_q;
	assign ovf_nxt = ovf_q || !keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q <= 1'b0;
			busy_q <= 1'b0;
			few_q <= 1'b0;
			drop_q <= 1'b0;
			entry_q <= '0;
		end else begin
			entry_q.valid <= in_xfer;
			entry_q.keep <= keep;
			entry_q.last <= s_tlast;
			entry_q.x <= s_tdata[COORD_W-1:0];
			entry_q.y <= s_tdata[2*COORD_W-1:COORD_W];
			if (in_xfer) begin
				if (s_tlast) begin
					count_q <= '0;
					ovf_q <= 1'b0;
					busy_q <= 1'b1;
					few_q <= (count_nxt < CNT_TWO);
					drop_q <= ovf_nxt;
				end else begin
					count_q <= count_nxt;
					ovf_q <= ovf_nxt;
				end
			end else if (out_xfer) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		entry_idx_q <= count_q;
	end

	// Cell chain
	assign pt_chain[0] = entry_q;
	assign idx_chain[0] = entry_idx_q;

	for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
		logic [SQ_W-1:0] best_in;
		if (k == 0) begin : g_head
			assign best_in = SQ_ALL_ONES;
		end else begin : g_body
			assign best_in = min_chain[k-1].best;
		end
		cpd_cell #(
			.CNT_W(CNT_W),
			.CELL_IDX(k)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.pt_in(pt_chain[k]),
			.idx_in(idx_chain[k]),
			.best_in(best_in),
			.pt_out(pt_chain[k+1]),
			.idx_out(idx_chain[k+1]),
			.min_out(min_chain[k])
		);
	end

	// Fold each point's minimum into the set minimum.
	assign tail = min_chain[MAX_POINTS-1];
	assign merged = (tail.best < gbest_q) ? tail.best : gbest_q;
	assign sq_start = tail.valid && tail.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gbest_q <= SQ_ALL_ONES;
		end else if (tail.valid) begin
			gbest_q <= tail.last ? SQ_ALL_ONES : merged;
		end
	end

	cpd_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sq_start),
		.radicand(merged),
		.done(sq_done),
		.root(sq_root)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (sq_done) begin
			m_valid_q <= 1'b1;
		end else if (out_xfer) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sq_done) begin
			dist_q <= few_q ? '0 : sq_root;
			nopair_q <= few_q || (sq_root >= far_limit_q);
			dropped_q <= drop_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {{(32-DIST_W){1'b0}}, dist_q};
	assign m_tuser = {dropped_q, nopair_q};

`ifndef ASSERT_OFF
	a_stall_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input accepted while a result is pending");
	a_done_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> busy_q)
		else $error("square root finished with no set in flight");
	a_tail_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sq_start |-> (busy_q && !m_valid_q))
		else $error("set end left the chain outside a busy period");
	a_count_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && s_tlast) |=> (count_q == '0 && !ovf_q))
		else $error("set state not cleared after set end");
	a_exit_starts_root: assert property (@(posedge clk) disable iff (!arst_n)
		(pt_chain[MAX_POINTS].valid && pt_chain[MAX_POINTS].last) |-> ##2 sq_start)
		else $error("set end left the chain without starting the square root");
	a_exit_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pt_chain[MAX_POINTS].valid && pt_chain[MAX_POINTS].keep) |->
			(idx_chain[MAX_POINTS] < CNT_MAX))
		else $error("kept point carried an index beyond capacity");
`endif

endmodule

### rtl/core/cpd_cell.sv
// One cell of the point chain: holds one stored point and folds its squared
// distance to each passing point into the running minimum. Depends on cpd_pkg.
module cpd_cell
	import cpd_pkg::*;
#(
	parameter int CNT_W = 7,
	parameter int CELL_IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  pt_t              pt_in,
	input  logic [CNT_W-1:0] idx_in,
	input  logic [SQ_W-1:0]  best_in,
	output pt_t              pt_out,
	output logic [CNT_W-1:0] idx_out,
	output min_t             min_out
);

	localparam logic [CNT_W-1:0] K = CNT_W'(CELL_IDX);

	pt_t pt_q;
	logic [CNT_W-1:0] idx_q;
	logic signed [COORD_W-1:0] sx_q, sy_q;

	logic v_s1, last_s1, en_s1;
	logic [COORD_W-1:0] dx_s1, dy_s1;
	logic v_s2, last_s2, en_s2;
	logic [2*COORD_W-1:0] sqx_s2, sqy_s2;
	min_t min_q;

	logic [COORD_W:0] diff_x, diff_y, neg_x, neg_y;
	logic [COORD_W-1:0] mag_x, mag_y;
	logic cmp_en, store_en;
	logic [2*COORD_W:0] sum_sq;
	logic [SQ_W-1:0] cand;

	assign diff_x = {pt_in.x[COORD_W-1], pt_in.x} - {sx_q[COORD_W-1], sx_q};
	assign diff_y = {pt_in.y[COORD_W-1], pt_in.y} - {sy_q[COORD_W-1], sy_q};
	assign neg_x = ~diff_x + 1'b1;
	assign neg_y = ~diff_y + 1'b1;
	assign mag_x = diff_x[COORD_W] ? neg_x[COORD_W-1:0] : diff_x[COORD_W-1:0];
	assign mag_y = diff_y[COORD_W] ? neg_y[COORD_W-1:0] : diff_y[COORD_W-1:0];

	assign cmp_en = pt_in.valid && pt_in.keep && (idx_in > K);
	assign store_en = pt_in.valid && pt_in.keep && (idx_in == K);

	assign sum_sq = {1'b0, sqx_s2} + {1'b0, sqy_s2};
	assign cand = {{(SQ_W-2*COORD_W-1){1'b0}}, sum_sq};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_q <= '0;
			v_s1 <= 1'b0;
			last_s1 <= 1'b0;
			en_s1 <= 1'b0;
			v_s2 <= 1'b0;
			last_s2 <= 1'b0;
			en_s2 <= 1'b0;
			min_q.valid <= 1'b0;
			min_q.last <= 1'b0;
			min_q.best <= SQ_ALL_ONES;
		end else begin
			pt_q <= pt_in;
			v_s1 <= pt_in.valid;
			last_s1 <= pt_in.last;
			en_s1 <= cmp_en;
			v_s2 <= v_s1;
			last_s2 <= last_s1;
			en_s2 <= en_s1;
			min_q.valid <= v_s2;
			min_q.last <= last_s2;
			min_q.best <= (en_s2 && (cand < best_in)) ? cand : best_in;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_in;
		dx_s1 <= mag_x;
		dy_s1 <= mag_y;
		sqx_s2 <= {{COORD_W{1'b0}}, dx_s1} * {{COORD_W{1'b0}}, dx_s1};
		sqy_s2 <= {{COORD_W{1'b0}}, dy_s1} * {{COORD_W{1'b0}}, dy_s1};
		if (store_en) begin
			sx_q <= pt_in.x;
			sy_q <= pt_in.y;
		end
	end

	assign pt_out = pt_q;
	assign idx_out = idx_q;
	assign min_out = min_q;

endmodule

### rtl/core/cpd_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on cpd_pkg for widths and the state type.
module cpd_sqrt
	import cpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   radicand,
	output logic              done,
	output logic [DIST_W-1:0] root
);

	sq_state_t state_q, state_nxt;
	logic [SQRT_CNT_W-1:0] cnt_q;
	logic [SQ_W-1:0] rad_q;
	logic [SQRT_REM_W-1:0] rem_q;
	logic [DIST_W-1:0] root_q;
	logic done_q;

	logic step_en, last_step;
	logic [SQRT_REM_W-1:0] rem_sh, trial;

	assign last_step = (cnt_q == SQRT_CNT_W'(SQRT_STEPS - 1));
	assign rem_sh = {rem_q[SQRT_REM_W-3:0], rad_q[SQ_W-1:SQ_W-2]};
	assign trial = {1'b0, root_q, 2'b01};

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			SQ_IDLE: begin
				if (start) state_nxt = SQ_RUN;
			end
			SQ_RUN: begin
				if (last_step) state_nxt = SQ_IDLE;
			end
			default: state_nxt = SQ_IDLE;
		endcase
	end

	always_comb begin
		case (state_q)
			SQ_RUN: step_en = 1'b1;
			default: step_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q <= step_en && last_step;
			if (step_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			rad_q <= {rad_q[SQ_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				root_q <= {root_q[DIST_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				root_q <= {root_q[DIST_W-2:0], 1'b0};
			end
		end else if (start) begin
			rad_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### tb/sv/closest_pair_distance_checker.sv
`timescale 1ns / 100ps
// Checker for closest_pair_distance: follows the point stream, the result stream and the
// register port, predicts each set's answer and compares it. Depends on cpd_pkg.
module closest_pair_distance_checker
	import cpd_pkg::*;
#(
	parameter int MAX_POINTS = CPD_MAX_POINTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [47:0]       s_tdata,  // coord_x [23:0], coord_y [47:24]
	input  logic              s_tlast,  // set_end
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [31:0]       m_tdata,  // min_distance [24:0], zero [31:25]
	input  logic [1:0]        m_tuser,  // no_pair [0], points_dropped [1]
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic [DATA_W-1:0] prdata,
	input  logic              pready,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic no_pair;
		logic dropped;
	} set_answer_t;

	logic signed [COORD_W-1:0] held_x [MAX_POINTS];
	logic signed [COORD_W-1:0] held_y [MAX_POINTS];
	int held_count;
	longint unsigned nearest_square;
	logic spilled;
	logic [DIST_W-1:0] limit_reg;
	set_answer_t awaited_answers [$];
	int errors;

	function automatic logic [DIST_W-1:0] floor_root(input longint unsigned sq);
		longint unsigned guess;
		longint unsigned trial;
		guess = 0;
		for (int b = DIST_W - 1; b >= 0; b--) begin
			trial = guess | (64'd1 << b);
			if (trial * trial <= sq) begin
				guess = trial;
			end
		end
		return guess[DIST_W-1:0];
	endfunction

	task automatic note_failure(input string msg);
		errors++;
		if (errors <= 10) begin
			$display("%0t: %s", $time, msg);
		end
	endtask

	task automatic forget_set();
		held_count = 0;
		nearest_square = {SQ_W{1'b1}};
		spilled = 1'b0;
	endtask

	task automatic absorb_point(input logic signed [COORD_W-1:0] px,
			input logic signed [COORD_W-1:0] py, input logic closing);
		longint dx;
		longint dy;
		longint unsigned sq;
		set_answer_t ans;
		if (held_count < MAX_POINTS) begin
			for (int i = 0; i < held_count; i++) begin
				dx = longint'(px) - longint'(held_x[i]);
				dy = longint'(py) - longint'(held_y[i]);
				if (dx < 0) begin
					dx = -dx;
				end
				if (dy < 0) begin
					dy = -dy;
				end
				sq = dx * dx + dy * dy;
				if (sq < nearest_square) begin
					nearest_square = sq;
				end
			end
			held_x[held_count] = px;
			held_y[held_count] = py;
			held_count++;
		end else begin
			spilled = 1'b1;
		end
		if (closing) begin
			if (held_count < 2) begin
				ans.distance = '0;
				ans.no_pair = 1'b1;
			end else begin
				ans.distance = floor_root(nearest_square);
				ans.no_pair = ans.distance >= limit_reg;
			end
			ans.dropped = spilled;
			awaited_answers.insert(awaited_answers.size(), ans);
			forget_set();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		set_answer_t seen;
		set_answer_t want;
		if (!arst_n) begin
			forget_set();
			limit_reg = FAR_LIMIT_RESET;
			awaited_answers.delete();
			errors = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (psel && penable && pready && (paddr >> 2) == REG_FAR_LIMIT) begin
				if (pwrite) begin
					limit_reg = pwdata[DIST_W-1:0];
				end else if (prdata !== {{(DATA_W - DIST_W){1'b0}}, limit_reg}) begin
					note_failure($sformatf("far_limit read: expected %0d, got %0d",
						limit_reg, prdata));
				end
			end
			if (s_tvalid && s_tready) begin
				absorb_point(s_tdata[COORD_W-1:0], s_tdata[2*COORD_W-1:COORD_W], s_tlast);
			end
			if (m_tvalid && m_tready) begin
				seen.distance = m_tdata[DIST_W-1:0];
				seen.no_pair = m_tuser[0];
				seen.dropped = m_tuser[1];
				if (awaited_answers.size() == 0) begin
					note_failure($sformatf("result with none expected: dist %0d nopair %b drop %b",
						seen.distance, seen.no_pair, seen.dropped));
				end else begin
					want = awaited_answers.pop_front();
					if (seen.distance !== want.distance || seen.no_pair !== want.no_pair ||
							seen.dropped !== want.dropped) begin
						note_failure($sformatf(
							"expected dist %0d nopair %b drop %b, got dist %0d nopair %b drop %b",
							want.distance, want.no_pair, want.dropped,
							seen.distance, seen.no_pair, seen.dropped));
					end
				end
			end
			pending <= awaited_answers.size();
			fail_count <= errors;
		end
	end

endmodule

### tb/sv/closest_pair_distance_tb.sv
`timescale 1ns / 100ps
// Top of the closest_pair_distance regression: clock, reset, point stream, result
// back-pressure and register traffic. Relies on cpd_pkg and closest_pair_distance_checker.
module closest_pair_distance_tb;
	import cpd_pkg::*;

	localparam int MAX_POINTS = CPD_MAX_POINTS;
	localparam int DRAIN_CYCLES = MAX_POINTS + 40;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int PHASE_COUNT = 8;
	localparam int PHASE_POINTS = 190;
	localparam logic [COORD_W-1:0] COORD_MIN = 24'h800000;
	localparam logic [COORD_W-1:0] COORD_MAX = 24'h7FFFFF;
	localparam logic [DIST_W-1:0] LIMIT_TOP = 25'd23726566;
	localparam logic [ADDR_W-1:0] LIMIT_ADDR = ADDR_W'(REG_FAR_LIMIT) << 2;
	localparam logic [ADDR_W-1:0] SPARE_ADDR = 3'd4;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [47:0]       s_tdata = '0;  // coord_x [23:0], coord_y [47:24]
	logic              s_tlast = 1'b0;  // set_end
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [31:0]       m_tdata;  // min_distance [24:0], zero [31:25]
	logic [1:0]        m_tuser;  // no_pair [0], points_dropped [1]
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int fail_count;
	int pending;
	int cycle_count = 0;
	int hold_left = 0;
	int points_sent = 0;
	logic steady = 1'b0;

	closest_pair_distance dut (.*);

	closest_pair_distance_checker answer_check (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("closest_pair_distance regression: fail");
			$finish;
		end
	end

	function automatic int stall_length();
		if ($urandom_range(0, 99) < 85) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
		end else if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!steady && $urandom_range(0, 99) < 25) begin
			m_tready <= 1'b0;
			hold_left <= stall_length() - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
			input logic closing);
		int gap;
		gap = (steady || $urandom_range(0, 99) < 60) ? 0 : stall_length();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {py, px};
		s_tlast <= closing;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		points_sent++;
	endtask

	task automatic reg_access(input logic wr, input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_limit(input logic [DIST_W-1:0] limit);
		reg_access(1'b1, LIMIT_ADDR, DATA_W'(limit));
		reg_access(1'b0, LIMIT_ADDR, '0);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_random_set();
		int n;
		int pick;
		int spread;
		int cx;
		int cy;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			n = 1;
		end else if (pick < 75) begin
			n = $urandom_range(2, 8);
		end else if (pick < 88) begin
			n = $urandom_range(9, 40);
		end else if (pick < 94) begin
			n = MAX_POINTS;
		end else begin
			n = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 8);
		end
		spread = $urandom_range(0, 22);
		cx = int'($urandom_range(0, 8388608)) - 4194304;
		cy = int'($urandom_range(0, 8388608)) - 4194304;
		px = COORD_W'(cx);
		py = COORD_W'(cy);
		steady = $urandom_range(0, 99) < 15;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				px = COORD_W'($urandom);
				py = COORD_W'($urandom);
			end else if (pick >= 20) begin
				px = COORD_W'(cx + int'($urandom_range(0, (2 << spread) - 2)) -
					((1 << spread) - 1));
				py = COORD_W'(cy + int'($urandom_range(0, (2 << spread) - 2)) -
					((1 << spread) - 1));
			end
			send_point(px, py, i == n - 1);
		end
	endtask

	initial begin
		int phase_start;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		reg_access(1'b0, LIMIT_ADDR, '0);
		send_point('0, '0, 1'b1);
		send_point(COORD_MIN, COORD_MIN, 1'b0);
		send_point(COORD_MAX, COORD_MAX, 1'b1);
		send_point(COORD_MAX, COORD_MIN, 1'b0);
		send_point(COORD_MAX, COORD_MIN, 1'b1);
		send_point('0, '0, 1'b0);
		send_point(24'd768, 24'd1024, 1'b0);
		send_point(24'd100, -24'sd100, 1'b0);
		send_point(-24'sd5, 24'd7, 1'b1);
		send_point(COORD_MIN, '0, 1'b0);
		send_point(COORD_MAX, '0, 1'b1);
		settle();

		set_limit('0);
		send_point(24'd1234, -24'sd4321, 1'b0);
		send_point(24'd1234, -24'sd4321, 1'b1);
		send_point(24'd256, 24'd256, 1'b0);
		send_point(24'd512, 24'd256, 1'b1);
		settle();

		set_limit(LIMIT_TOP);
		reg_access(1'b1, SPARE_ADDR, 32'h0000_0100);
		send_point(COORD_MIN, COORD_MIN, 1'b0);
		send_point(COORD_MAX, COORD_MAX, 1'b1);
		settle();

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0: set_limit('0);
				1: set_limit(LIMIT_TOP);
				2: set_limit(FAR_LIMIT_RESET);
				3: set_limit(25'd1);
				default: set_limit(DIST_W'($urandom_range(0, LIMIT_TOP)));
			endcase
			phase_start = points_sent;
			while (points_sent - phase_start < PHASE_POINTS) begin
				send_random_set();
			end
			steady = 1'b0;
			settle();
		end

		if (fail_count == 0 && pending == 0) begin
			$display("closest_pair_distance regression: pass");
		end else begin
			$display("closest_pair_distance regression: fail");
		end
		$finish;
	end

endmodule

### sim.f
rtl/core/cpd_pkg.sv
rtl/core/cpd_cell.sv
rtl/core/cpd_sqrt.sv
rtl/core/closest_pair_distance.sv
tb/sv/closest_pair_distance_checker.sv
tb/sv/closest_pair_distance_tb.sv
